// File: hw/rtl/rd_pkg.sv
// Shared constants and codes for the record deframer.
`timescale 1ns / 1ps
`default_nettype none

package rd_pkg;

	// Fixed record header: sync word, name length, data length, 4 bytes each
	localparam int HEADER_BYTES = 12;

	// Default width of the buffer length and byte counters
	localparam int LENGTH_BITS_DEF = 16;

	// Reset value of the name length limit
	localparam logic [7:0] MAX_NAME_RESET = 8'd79;

	// Register index, taken from paddr[2]
	localparam logic REG_SYNC_WORD = 1'b0;
	localparam logic REG_MAX_NAME  = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_DATA   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// Error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_SYNC     = 2'd1,
		ERR_NAME_LEN = 2'd2,
		ERR_SIZE     = 2'd3
	} err_t;

endpackage

`default_nettype wire

// File: hw/rtl/record_deframer_top.sv
// Record deframer: splits an aggregated byte buffer into header, name and data results.
// Each accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle; the only hold-off is a stalled full result register.
// Each byte is decided in one pass through the phase logic between the two registers.
// Reset: control state cleared, sync_word 0, max_name_length 79; all bytes are ignored
// until a byte with first_of_buffer set opens a buffer.
`timescale 1ns / 1ps
`default_nettype none

module record_deframer_top #(
	parameter int LENGTH_BITS = rd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB-style configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Byte input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        first_of_buffer,
	input  wire logic [15:0] buffer_length,
	input  wire logic        is_aggregate,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic [7:0]       name_len,
	output logic [15:0]      data_len,
	output logic [1:0]       error_code,
	output logic             last
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC,
		PH_NAMELEN,
		PH_DATALEN,
		PH_NAME,
		PH_DATA,
		PH_PASS
	} phase_t;

	typedef logic [LENGTH_BITS-1:0] len_t;

	// Configuration registers
	logic [31:0] sync_word_q;
	logic [7:0]  max_name_q;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [15:0] blen_s1;
	logic        agg_s1;

	// Parser state
	phase_t      phase_q;
	logic [1:0]  cnt_q;
	logic [23:0] field_q;
	logic [7:0]  name_left_q;
	len_t        data_left_q;
	len_t        remain_q;
	len_t        total_q;
	logic        stopped_q;
	logic [7:0]  rec_nl_q;
	logic [15:0] rec_dl_q;

	// Result register
	logic        out_valid_q;
	rd_pkg::kind_t kind_q;
	logic [7:0]  obyte_q;
	logic [7:0]  onl_q;
	logic [15:0] odl_q;
	rd_pkg::err_t err_q;
	logic        last_q;

	logic        in_accept;
	logic        advance;
	logic        cfg_write;

	// Next-state and result signals
	phase_t      phase_d;
	logic [1:0]  cnt_d;
	logic [23:0] field_d;
	logic [7:0]  name_left_d;
	len_t        data_left_d;
	len_t        remain_d;
	len_t        total_d;
	logic        stopped_d;
	logic [7:0]  rec_nl_d;
	logic [15:0] rec_dl_d;
	logic        emit;
	rd_pkg::kind_t kind_d;
	logic [7:0]  obyte_d;
	logic [7:0]  onl_d;
	logic [15:0] odl_d;
	rd_pkg::err_t err_d;
	logic        last_d;
	logic [31:0] word;
	len_t        remain_dec;
	logic [7:0]  name_dec;
	len_t        data_dec;

	// Handshakes
	assign in_accept = in_valid && !in_stall;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= '0;
			max_name_q  <= rd_pkg::MAX_NAME_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == rd_pkg::REG_SYNC_WORD) begin
				sync_word_q <= pwdata;
			end else begin
				max_name_q <= pwdata[7:0];
			end
		end
	end

	// Configuration read
	always_comb begin
		if (paddr[2] == rd_pkg::REG_MAX_NAME) begin
			prdata = {24'd0, max_name_q};
		end else begin
			prdata = sync_word_q;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= in_byte;
			first_s1 <= first_of_buffer;
			blen_s1  <= buffer_length;
			agg_s1   <= is_aggregate;
		end
	end

	// Per-byte phase logic
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		field_d     = field_q;
		name_left_d = name_left_q;
		data_left_d = data_left_q;
		remain_d    = remain_q;
		total_d     = total_q;
		stopped_d   = stopped_q;
		rec_nl_d    = rec_nl_q;
		rec_dl_d    = rec_dl_q;
		emit        = 1'b0;
		kind_d      = rd_pkg::KIND_HEADER;
		obyte_d     = '0;
		onl_d       = '0;
		odl_d       = '0;
		err_d       = rd_pkg::ERR_NONE;
		last_d      = 1'b0;

		// A first byte opens a new buffer and drops whatever was in progress
		if (first_s1) begin
			total_d     = len_t'(blen_s1);
			remain_d    = len_t'(blen_s1);
			stopped_d   = 1'b0;
			phase_d     = agg_s1 ? PH_SYNC : PH_PASS;
			cnt_d       = '0;
			field_d     = '0;
			name_left_d = '0;
			data_left_d = '0;
			rec_nl_d    = '0;
			rec_dl_d    = '0;
		end

		word       = {byte_s1, field_d};
		remain_dec = remain_d - len_t'(1);
		name_dec   = name_left_d - 8'd1;
		data_dec   = data_left_d - len_t'(1);

		if (stopped_d || remain_d == '0) begin
			stopped_d = 1'b1;
		end else begin
			case (phase_d)
				PH_PASS: begin
					remain_d = remain_dec;
					emit     = 1'b1;
					kind_d   = rd_pkg::KIND_DATA;
					obyte_d  = byte_s1;
					odl_d    = 16'(total_d);
					last_d   = (remain_dec == '0);
				end
				PH_SYNC, PH_NAMELEN, PH_DATALEN: begin
					// Short tail: too few bytes left for another record
					if (phase_d == PH_SYNC && cnt_d == 2'd0 &&
							remain_d <= len_t'(rd_pkg::HEADER_BYTES)) begin
						stopped_d = 1'b1;
						phase_d   = PH_IDLE;
					end else begin
						remain_d = remain_dec;
						if (cnt_d != 2'd3) begin
							// Collect little-endian field bytes
							case (cnt_d)
								2'd0:    field_d[7:0]   = byte_s1;
								2'd1:    field_d[15:8]  = byte_s1;
								default: field_d[23:16] = byte_s1;
							endcase
							cnt_d = cnt_d + 2'd1;
						end else begin
							cnt_d   = '0;
							field_d = '0;
							case (phase_d)
								PH_SYNC: begin
									if (word != sync_word_q) begin
										stopped_d = 1'b1;
										phase_d   = PH_IDLE;
										emit      = 1'b1;
										kind_d    = rd_pkg::KIND_ERROR;
										err_d     = rd_pkg::ERR_SYNC;
										last_d    = 1'b1;
									end else begin
										phase_d = PH_NAMELEN;
									end
								end
								PH_NAMELEN: begin
									if (word > {24'd0, max_name_q}) begin
										stopped_d = 1'b1;
										phase_d   = PH_IDLE;
										emit      = 1'b1;
										kind_d    = rd_pkg::KIND_ERROR;
										err_d     = rd_pkg::ERR_NAME_LEN;
										last_d    = 1'b1;
									end else begin
										name_left_d = word[7:0];
										phase_d     = PH_DATALEN;
									end
								end
								default: begin
									// Unsigned size check without wrap
									if (({1'b0, word} + {25'd0, name_left_d}) >
											33'(remain_dec)) begin
										stopped_d = 1'b1;
										phase_d   = PH_IDLE;
										emit      = 1'b1;
										kind_d    = rd_pkg::KIND_ERROR;
										err_d     = rd_pkg::ERR_SIZE;
										last_d    = 1'b1;
									end else begin
										data_left_d = len_t'(word);
										rec_nl_d    = name_left_d;
										rec_dl_d    = word[15:0];
										if (name_left_d != '0) begin
											phase_d = PH_NAME;
										end else if (word != '0) begin
											phase_d = PH_DATA;
										end else begin
											phase_d = PH_SYNC;
										end
										emit   = 1'b1;
										kind_d = rd_pkg::KIND_HEADER;
										onl_d  = name_left_d;
										odl_d  = word[15:0];
										last_d = (name_left_d == '0) && (word == '0);
									end
								end
							endcase
						end
					end
				end
				PH_NAME: begin
					remain_d    = remain_dec;
					name_left_d = name_dec;
					if (name_dec == '0) begin
						phase_d = (data_left_d != '0) ? PH_DATA : PH_SYNC;
					end
					emit    = 1'b1;
					kind_d  = rd_pkg::KIND_NAME;
					obyte_d = byte_s1;
					onl_d   = rec_nl_d;
					odl_d   = rec_dl_d;
					last_d  = (name_dec == '0) && (data_left_d == '0);
				end
				PH_DATA: begin
					remain_d    = remain_dec;
					data_left_d = data_dec;
					if (data_dec == '0) begin
						phase_d = PH_SYNC;
					end
					emit    = 1'b1;
					kind_d  = rd_pkg::KIND_DATA;
					obyte_d = byte_s1;
					onl_d   = rec_nl_d;
					odl_d   = rec_dl_d;
					last_d  = (data_dec == '0);
				end
				default: begin
					stopped_d = 1'b1;
				end
			endcase
		end
	end

	// Parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			field_q     <= '0;
			name_left_q <= '0;
			data_left_q <= '0;
			remain_q    <= '0;
			total_q     <= '0;
			stopped_q   <= 1'b1;
			rec_nl_q    <= '0;
			rec_dl_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				field_q     <= field_d;
				name_left_q <= name_left_d;
				data_left_q <= data_left_d;
				remain_q    <= remain_d;
				total_q     <= total_d;
				stopped_q   <= stopped_d;
				rec_nl_q    <= rec_nl_d;
				rec_dl_q    <= rec_dl_d;
				// result register is empty or being taken here
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q  <= kind_d;
			obyte_q <= obyte_d;
			onl_q   <= onl_d;
			odl_q   <= odl_d;
			err_q   <= err_d;
			last_q  <= last_d;
		end
	end

	// Result port
	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign out_byte   = obyte_q;
	assign name_len   = onl_q;
	assign data_len   = odl_q;
	assign error_code = err_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	// An error result always closes the record and carries a real code
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == rd_pkg::KIND_ERROR) |->
			(last && error_code != rd_pkg::ERR_NONE))
		else $error("error result without last or code");

	// After an error is produced the parser ignores the rest of the buffer
	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && kind_d == rd_pkg::KIND_ERROR) |=> stopped_q)
		else $error("parser still running after error");

	// Idle phase only while stopped
	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> stopped_q)
		else $error("idle phase while not stopped");

	// Name bytes only for records with a nonzero name
	a_name_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == rd_pkg::KIND_NAME) |-> (name_len != '0))
		else $error("name byte with zero name length");
`endif

endmodule

`default_nettype wire

// File: test/record_deframer_top_test.sv
// Self-checking testbench for the record deframer: random buffers against a built-in predictor.
`timescale 1ns / 1ps

module record_deframer_top_test;

	localparam int HOLD_CYCLES = 300;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SYNC, PH_NAMELEN, PH_DATALEN, PH_NAME, PH_DATA, PH_PASS
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [15:0] blen;
		logic        agg;
	} byte_item_t;

	typedef struct packed {
		rd_pkg::kind_t kind;
		logic [7:0]    data;
		logic [7:0]    nlen;
		logic [15:0]   dlen;
		rd_pkg::err_t  err;
		logic          last;
	} deframed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        first_of_buffer = 1'b0;
	logic [15:0] buffer_length = '0;
	logic        is_aggregate = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [7:0]  name_len;
	logic [15:0] data_len;
	logic [1:0]  error_code;
	logic        last;

	// Stimulus and scoreboard storage
	byte_item_t byte_stream[$];
	deframed_t  predicted_results[$];
	byte_item_t offered;
	deframed_t  predicted;
	deframed_t  observed;
	int         queued_count = 0;
	int         mismatches = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	logic       hold_req = 1'b0;
	int         hold_cnt = 0;

	// Predictor copy of the configuration and parse state
	logic [31:0]  sync_cfg = '0;
	logic [7:0]   max_name_cfg = rd_pkg::MAX_NAME_RESET;
	parse_phase_t ph = PH_IDLE;
	int           field_cnt = 0;
	logic [31:0]  field_acc = '0;
	logic [7:0]   name_left = '0;
	logic [15:0]  data_left = '0;
	logic [15:0]  buf_pos = '0;
	logic [15:0]  buf_len = '0;
	logic         agg_mode = 1'b0;
	logic         stopped = 1'b1;
	logic [7:0]   rec_name_len = '0;
	logic [15:0]  rec_data_len = '0;

	record_deframer_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.first_of_buffer(first_of_buffer),
		.buffer_length  (buffer_length),
		.is_aggregate   (is_aggregate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.name_len       (name_len),
		.data_len       (data_len),
		.error_code     (error_code),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Error ends the buffer: one error result, rest ignored
	function automatic deframed_t abort_buffer(rd_pkg::err_t code);
		stopped = 1'b1;
		ph = PH_IDLE;
		return '{rd_pkg::KIND_ERROR, 8'd0, 8'd0, 16'd0, code, 1'b1};
	endfunction

	// Predict the result (if any) of one accepted byte
	function automatic bit deframe_step(input byte_item_t it, output deframed_t res);
		logic [31:0] word;
		res = '{rd_pkg::KIND_HEADER, 8'd0, 8'd0, 16'd0, rd_pkg::ERR_NONE, 1'b0};
		if (it.first) begin
			buf_len = it.blen;
			agg_mode = it.agg;
			buf_pos = '0;
			stopped = 1'b0;
			ph = it.agg ? PH_SYNC : PH_PASS;
			field_cnt = 0;
			field_acc = '0;
			name_left = '0;
			data_left = '0;
			rec_name_len = '0;
			rec_data_len = '0;
		end
		if (stopped || buf_pos >= buf_len) begin
			stopped = 1'b1;
			return 1'b0;
		end
		case (ph)
		PH_PASS: begin
			buf_pos++;
			res = '{rd_pkg::KIND_DATA, it.data, 8'd0, buf_len, rd_pkg::ERR_NONE,
				buf_pos == buf_len};
			return 1'b1;
		end
		PH_SYNC, PH_NAMELEN, PH_DATALEN: begin
			// a record needs more than a header's worth of bytes left
			if (ph == PH_SYNC && field_cnt == 0 &&
			    int'(buf_pos) + rd_pkg::HEADER_BYTES >= int'(buf_len)) begin
				stopped = 1'b1;
				ph = PH_IDLE;
				return 1'b0;
			end
			field_acc |= 32'(it.data) << (8 * field_cnt);
			field_cnt++;
			buf_pos++;
			if (field_cnt < 4)
				return 1'b0;
			field_cnt = 0;
			word = field_acc;
			field_acc = '0;
			if (ph == PH_SYNC) begin
				if (word != sync_cfg) begin
					res = abort_buffer(rd_pkg::ERR_SYNC);
					return 1'b1;
				end
				ph = PH_NAMELEN;
				return 1'b0;
			end
			if (ph == PH_NAMELEN) begin
				if (word > 32'(max_name_cfg)) begin
					res = abort_buffer(rd_pkg::ERR_NAME_LEN);
					return 1'b1;
				end
				name_left = word[7:0];
				ph = PH_DATALEN;
				return 1'b0;
			end
			// unsigned size check, no wrap
			if (33'(name_left) + 33'(word) > 33'(buf_len - buf_pos)) begin
				res = abort_buffer(rd_pkg::ERR_SIZE);
				return 1'b1;
			end
			data_left = word[15:0];
			rec_name_len = name_left;
			rec_data_len = word[15:0];
			ph = (name_left != 0) ? PH_NAME : ((data_left != 0) ? PH_DATA : PH_SYNC);
			res = '{rd_pkg::KIND_HEADER, 8'd0, rec_name_len, rec_data_len, rd_pkg::ERR_NONE,
				name_left == 0 && data_left == 0};
			return 1'b1;
		end
		PH_NAME: begin
			buf_pos++;
			if (name_left != 0)
				name_left--;
			if (name_left == 0)
				ph = (data_left != 0) ? PH_DATA : PH_SYNC;
			res = '{rd_pkg::KIND_NAME, it.data, rec_name_len, rec_data_len, rd_pkg::ERR_NONE,
				name_left == 0 && data_left == 0};
			return 1'b1;
		end
		PH_DATA: begin
			buf_pos++;
			if (data_left != 0)
				data_left--;
			if (data_left == 0)
				ph = PH_SYNC;
			res = '{rd_pkg::KIND_DATA, it.data, rec_name_len, rec_data_len, rd_pkg::ERR_NONE,
				data_left == 0};
			return 1'b1;
		end
		default: begin
			stopped = 1'b1;
			return 1'b0;
		end
		endcase
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	// Byte driver: predicts each accepted transaction, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (deframe_step(offered, predicted))
					predicted_results.push_back(predicted);
			end
			if (!in_valid || !in_stall) begin
				if (byte_stream.size() != 0 && $urandom_range(99) >= idle_pct) begin
					offered = byte_stream.pop_front();
					in_valid <= 1'b1;
					in_byte <= offered.data;
					first_of_buffer <= offered.first;
					buffer_length <= offered.blen;
					is_aggregate <= offered.agg;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result stall: random, or one long hold-off once requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				$error("unexpected result: kind %0d byte %0h", out_kind, out_byte);
				mismatches++;
			end else begin
				observed = predicted_results.pop_front();
				check_field("out_kind", observed.kind, out_kind);
				check_field("out_byte", observed.data, out_byte);
				check_field("name_len", observed.nlen, name_len);
				check_field("data_len", observed.dlen, data_len);
				check_field("error_code", observed.err, error_code);
				check_field("last", observed.last, last);
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_config(input logic [31:0] sw, input logic [7:0] mn);
		apb_write({rd_pkg::REG_SYNC_WORD, 2'b00}, sw);
		apb_write({rd_pkg::REG_MAX_NAME, 2'b00}, {24'($urandom), mn});
		sync_cfg = sw;
		max_name_cfg = mn;
	endtask

	// Everything sent, everything received, pipeline drained
	task automatic wait_idle();
		@(negedge clk);
		while (byte_stream.size() != 0 || in_valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_word(ref logic [7:0] body[$], input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			body.push_back(w[8*i +: 8]);
	endtask

	// Header fields little-endian, then name and data bytes where sensible
	task automatic append_record(ref logic [7:0] body[$], input logic [31:0] sw,
		input logic [31:0] nl, input logic [31:0] dl);
		push_word(body, sw);
		push_word(body, nl);
		push_word(body, dl);
		if (nl <= 32'(max_name_cfg))
			repeat (nl) body.push_back(8'($urandom));
		if (dl <= 300)
			repeat (dl) body.push_back(8'($urandom));
	endtask

	// Queue one buffer; noise in the sideband fields after the first byte
	task automatic queue_buffer(input logic [7:0] body[$], input logic [15:0] blen,
		input logic agg);
		byte_item_t it;
		for (int i = 0; i < body.size(); i++) begin
			it.data = body[i];
			it.first = (i == 0);
			it.blen = (i == 0) ? blen : 16'($urandom);
			it.agg = (i == 0) ? agg : 1'($urandom);
			byte_stream.push_back(it);
		end
		queued_count += (body.size() < int'(blen)) ? body.size() : int'(blen);
	endtask

	task automatic add_random_buffer();
		logic [7:0]  body[$];
		logic [31:0] sw;
		logic [31:0] nl;
		logic [31:0] dl;
		int          blen;
		logic        agg;
		agg = ($urandom_range(99) >= 20);
		if (!agg) begin
			repeat ($urandom_range(0, 24)) body.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) begin
				sw = sync_cfg;
				nl = $urandom_range(0, (max_name_cfg < 6) ? max_name_cfg : 6);
				dl = $urandom_range(0, 12);
				case ($urandom_range(24))
				0: sw = sw ^ (32'd1 << $urandom_range(31));
				1: nl = 32'(max_name_cfg) + $urandom_range(1, 2);
				2: nl = $urandom;
				3: dl = $urandom;
				4: nl = 32'(max_name_cfg);
				5: dl = $urandom_range(13, 300);
				default: ;
				endcase
				append_record(body, sw, nl, dl);
			end
		end
		blen = body.size();
		case ($urandom_range(11))
		// junk tail inside the length
		0: begin
			repeat ($urandom_range(1, 14)) body.push_back(8'($urandom));
			blen = body.size();
		end
		// length shorter than the content
		1: blen = $urandom_range(0, blen);
		// bytes past the end of the buffer
		2: repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
		// next buffer starts mid-buffer
		3: if (body.size() > 1)
			repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
		default: ;
		endcase
		if (body.size() == 0)
			body.push_back(8'($urandom));
		queue_buffer(body, 16'(blen), agg);
	endtask

	task automatic run_random(input int n);
		int target;
		target = queued_count + n;
		while (queued_count < target)
			add_random_buffer();
		wait_idle();
	endtask

	// Main sequence
	initial begin
		logic [7:0] body[$];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any buffer are dropped
		byte_stream.push_back('{8'hA7, 1'b0, 16'hFFFF, 1'b1});
		byte_stream.push_back('{8'h00, 1'b0, 16'h0000, 1'b0});
		// zero-length pass-through
		body = '{8'h5A};
		queue_buffer(body, 16'd0, 1'b0);
		// pass-through with extreme bytes and one byte past the end
		body = '{8'h00, 8'hFF, 8'h3C};
		queue_buffer(body, 16'd2, 1'b0);
		// good record with one name and one data byte
		body = {};
		append_record(body, 32'h0, 32'd1, 32'd1);
		queue_buffer(body, 16'd14, 1'b1);
		// empty record followed by a short tail
		body = {};
		append_record(body, 32'h0, 32'd0, 32'd0);
		body.push_back(8'h99);
		queue_buffer(body, 16'd13, 1'b1);
		// bad sync word
		body = {};
		push_word(body, 32'h0000_0001);
		body.push_back(8'h42);
		queue_buffer(body, 16'd40, 1'b1);
		// name length one over the limit
		body = {};
		push_word(body, 32'h0);
		push_word(body, 32'd80);
		queue_buffer(body, 16'd40, 1'b1);
		// data length that would wrap a signed check
		body = {};
		append_record(body, 32'h0, 32'd0, 32'hFFFF_FFFF);
		queue_buffer(body, 16'd40, 1'b1);
		// longest pass-through, dropped by the next buffer
		body = '{8'h11, 8'h22};
		queue_buffer(body, 16'hFFFF, 1'b0);
		wait_idle();

		write_config(32'hA5C3_1E7F, rd_pkg::MAX_NAME_RESET);
		run_random(260);

		idle_pct = 78;
		write_config(32'hFFFF_FFFF, 8'd255);
		run_random(260);

		idle_pct = 0;
		stall_pct = 78;
		write_config(32'h0000_0000, 8'd0);
		run_random(260);

		idle_pct = 38;
		stall_pct = 38;
		write_config($urandom, 8'($urandom_range(1, 254)));
		run_random(260);

		// long receiver hold-off while the sender keeps offering
		idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_req <= 1'b1;
		body = {};
		repeat (64) body.push_back(8'($urandom));
		queue_buffer(body, 16'd64, 1'b0);
		run_random(60);

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
